// File: rtl/zst_pkg.sv
package zst_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // size registers: reset value, lower clamp and bus width
   localparam int RESET_SIZE  = 1024;
   localparam int MIN_SIZE    = 3;
   localparam int CFG_DATA_W  = 11;
   localparam int CSR_IDX_W   = 2;

   localparam int ADDR_W   = $clog2(MAX_WIDTH);
   localparam int COL_W    = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
   localparam int FLUSH_W  = $clog2(MAX_WIDTH + 2);
   localparam int SIZE_W_A = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int SIZE_W   = (SIZE_W_A > CFG_DATA_W) ? SIZE_W_A : CFG_DATA_W;

   localparam int DEF_WIDTH  = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
   localparam int DEF_HEIGHT = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

   // line store word: bit 0 upper row, bit 1 middle row
   localparam int LINE_W = 2;
   localparam int WIN_W  = 9;

   // neighbor count limits for deletion
   localparam int NB_MIN = 2;
   localparam int NB_MAX = 6;

   // result queue
   localparam int OUT_DEPTH = 3;
   localparam int PTR_W     = $clog2(OUT_DEPTH);
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUB_PASS     = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // where the delayed pixel sits in its frame
   typedef struct packed {
      logic out_valid;
      logic interior;
      logic frame_end;
   } pos_info_type;

   typedef struct packed {
      logic pixel_out;
      logic out_valid;
      logic deleted;
      logic frame_end;
   } result_type;

endpackage

// File: rtl/zst_ram.sv
module zst_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/zst_decide.sv
module zst_decide (
   input  logic [zst_pkg::WIN_W-1:0] window,
   input  logic                      sub_pass,
   input  zst_pkg::pos_info_type     pos,
   output zst_pkg::result_type       result
);

   import zst_pkg::*;

   logic       p2, p3, p4, p5, p6, p7, p8, p9, ctr;
   logic [7:0] ring;
   logic [7:0] trans;
   logic [3:0] ones;
   logic       m1, m2;
   logic       del;

   // window: newest column in bits 2:0, oldest in 8:6, top row lowest bit
   assign p2  = window[3];
   assign p3  = window[0];
   assign p4  = window[1];
   assign p5  = window[2];
   assign p6  = window[5];
   assign p7  = window[8];
   assign p8  = window[7];
   assign p9  = window[6];
   assign ctr = window[4];

   assign ring = {p9, p8, p7, p6, p5, p4, p3, p2};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         trans[i] = ~ring[i] & ring[(i + 1) % 8];
      end
   end

   assign ones = 4'($countones(ring));
   assign m1   = sub_pass ? (p2 & p4 & p8) : (p2 & p4 & p6);
   assign m2   = sub_pass ? (p2 & p6 & p8) : (p4 & p6 & p8);

   assign del = pos.out_valid & pos.interior & ctr & $onehot(trans)
              & (ones inside {[4'(NB_MIN):4'(NB_MAX)]}) & ~m1 & ~m2;

   assign result.pixel_out = pos.out_valid & ctr & ~del;
   assign result.out_valid = pos.out_valid;
   assign result.deleted   = del;
   assign result.frame_end = pos.out_valid & pos.frame_end;

endmodule

// File: rtl/zhang_suen_thinning_pass.sv
// A result passes the line store read stage, then the output queue, where
// rsp_stall can hold it; it describes the pixel image_width+1 stream
// positions earlier. Throughput: 1 item per cycle while req_stall is
// low, set by one line store read and one write of a column per item.
// Reset: counters and registers to defaults (sub_pass 0, sizes 1024); line
// stores are not swept, since every entry feeding a result is written first.
module zhang_suen_thinning_pass (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic                           req_pixel_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pixel_out,
   output logic                           rsp_out_valid,
   output logic                           rsp_deleted,
   output logic                           rsp_frame_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [zst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [zst_pkg::CFG_DATA_W-1:0] csr_data
);

   import zst_pkg::*;

   // configuration
   logic             sub_pass_ff, sub_pass_in;
   logic [COL_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic             csr_write;
   logic             size_write;
   logic [SIZE_W-1:0] csr_wide;
   logic [SIZE_W-1:0] width_clamp, height_clamp;

   // frame position
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [FLUSH_W-1:0] flush_ff, flush_in;

   logic               accept;
   logic               tail;
   logic               restart;
   logic [COL_W-1:0]   col_eff, col_inc;
   logic [ROW_W-1:0]   row_eff, row_inc;
   logic [FLUSH_W-1:0] f_raw;
   logic [COL_W-1:0]   f_c;
   logic [COL_W-1:0]   pos_c;
   logic [ROW_W-1:0]   pos_r;
   logic [COL_W-1:0]   line_col;
   logic [ADDR_W-1:0]  rd_addr;
   logic               pix;
   pos_info_type       pos_info;

   // line store stage
   logic               sb_valid_ff, sb_valid_in;
   logic               sb_pix_ff;
   logic [ADDR_W-1:0]  sb_addr_ff;
   pos_info_type       sb_pos_ff;
   logic               sb_fwd_ff, sb_fwd_in;
   logic [LINE_W-1:0]  sb_fwd_data_ff;
   logic [LINE_W-1:0]  ram_rd_data;
   logic [LINE_W-1:0]  line_rd;
   logic [LINE_W-1:0]  line_wr;
   logic [WIN_W-1:0]   window_ff, window_in;
   result_type         result;

   // output queue
   result_type         queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push, pop;
   logic [CNT_W:0]     occupancy;
   result_type         head;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign csr_wide  = SIZE_W'(csr_data);

   assign width_clamp  = (csr_wide < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) :
                         (csr_wide > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : csr_wide;
   assign height_clamp = (csr_wide < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) :
                         (csr_wide > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : csr_wide;

   always_comb begin
      sub_pass_in = sub_pass_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      size_write  = 1'b0;
      if (csr_write) begin
         case (csr_index)
            CSR_SUB_PASS: begin
               sub_pass_in = csr_data[0];
            end
            CSR_IMAGE_WIDTH: begin
               width_in   = width_clamp[COL_W-1:0];
               size_write = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in  = height_clamp[ROW_W-1:0];
               size_write = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- input stage ----------------
   assign accept = req_valid & ~req_stall;

   always_comb begin
      tail    = flush_ff != '0;
      restart = (col_ff >= width_ff) || (row_ff >= height_ff);
      col_eff = restart ? '0 : col_ff;
      row_eff = restart ? '0 : row_ff;
      f_raw   = flush_ff - FLUSH_W'(1);
      f_c     = (f_raw > FLUSH_W'(width_ff)) ? width_ff : f_raw[COL_W-1:0];

      // flush positions continue as a virtual row just below the frame
      pos_r = tail ? height_ff : row_eff;
      pos_c = tail ? f_c : col_eff;

      if (tail) begin
         line_col = (f_c < width_ff) ? f_c : '0;
      end else begin
         line_col = col_eff;
      end
      rd_addr = line_col[ADDR_W-1:0];
      pix     = ~tail & ~req_kind & req_pixel_in;

      pos_info.out_valid = (pos_r >= ROW_W'(2)) || ((pos_r == ROW_W'(1)) && (pos_c != '0));
      pos_info.interior  = (pos_c >= COL_W'(2)) && (pos_c < width_ff) &&
                           (pos_r >= ROW_W'(2)) && (pos_r < height_ff);
      pos_info.frame_end = tail && (f_c == width_ff);

      col_inc = col_eff + COL_W'(1);
      row_inc = row_eff + ROW_W'(1);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      flush_in = flush_ff;
      if (size_write) begin
         col_in   = '0;
         row_in   = '0;
         flush_in = '0;
      end else if (accept) begin
         if (!tail) begin
            if (col_inc >= width_ff) begin
               col_in = '0;
               if (row_inc >= height_ff) begin
                  row_in   = '0;
                  flush_in = FLUSH_W'(1);
               end else begin
                  row_in = row_inc;
               end
            end else begin
               col_in = col_inc;
               row_in = row_eff;
            end
         end else if (f_c >= width_ff) begin
            col_in   = '0;
            row_in   = '0;
            flush_in = '0;
         end else begin
            flush_in = FLUSH_W'(f_c) + FLUSH_W'(2);
         end
      end
   end

   // same column read while the stage ahead writes it: take the new word
   assign sb_fwd_in   = accept & sb_valid_ff & (rd_addr == sb_addr_ff);
   assign sb_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_pass_ff <= 1'b0;
         width_ff    <= COL_W'(DEF_WIDTH);
         height_ff   <= ROW_W'(DEF_HEIGHT);
         col_ff      <= '0;
         row_ff      <= '0;
         flush_ff    <= '0;
         sb_valid_ff <= 1'b0;
         sb_fwd_ff   <= 1'b0;
         window_ff   <= '0;
      end else begin
         sub_pass_ff <= sub_pass_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         flush_ff    <= flush_in;
         sb_valid_ff <= sb_valid_in;
         sb_fwd_ff   <= sb_fwd_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sb_pix_ff      <= pix;
         sb_addr_ff     <= rd_addr;
         sb_pos_ff      <= pos_info;
         sb_fwd_data_ff <= line_wr;
      end
   end

   // ---------------- line store stage ----------------
   zst_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (sb_valid_ff),
      .wr_addr (sb_addr_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign line_rd   = sb_fwd_ff ? sb_fwd_data_ff : ram_rd_data;
   // rows move up: old middle becomes upper, new pixel becomes middle
   assign line_wr   = {sb_pix_ff, line_rd[1]};
   assign window_in = sb_valid_ff ? {window_ff[5:0], sb_pix_ff, line_rd[1], line_rd[0]}
                                  : window_ff;

   zst_decide u_decide (
      .window   (window_in),
      .sub_pass (sub_pass_ff),
      .pos      (sb_pos_ff),
      .result   (result)
   );

   // ---------------- output queue ----------------
   assign push      = sb_valid_ff;
   assign pop       = rsp_valid & ~rsp_stall;
   assign occupancy = (CNT_W + 1)'(cnt_ff) + (CNT_W + 1)'(sb_valid_ff);
   assign req_stall = occupancy >= (CNT_W + 1)'(OUT_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   assign head          = queue_ff[rd_ptr_ff];
   assign rsp_valid     = cnt_ff != '0;
   assign rsp_pixel_out = head.pixel_out;
   assign rsp_out_valid = head.out_valid;
   assign rsp_deleted   = head.deleted;
   assign rsp_frame_end = head.frame_end;

`ifndef NO_ASSERTIONS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(sb_valid_ff && (cnt_ff == CNT_W'(OUT_DEPTH))))
      else $error("result queue written while full");

   a_fwd_needs_prior: assert property (@(posedge clock) disable iff (reset)
      sb_fwd_ff |-> $past(sb_valid_ff))
      else $error("line store bypass without a transaction ahead");

   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      flush_ff <= FLUSH_W'(width_ff) + FLUSH_W'(1))
      else $error("flush position beyond row length");

   a_deleted_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_deleted) |-> (rsp_out_valid && !rsp_pixel_out))
      else $error("deleted pixel still set or without a pixel");

   a_frame_end_in_tail: assert property (@(posedge clock) disable iff (reset)
      (accept && pos_info.frame_end) |=> (flush_ff == '0))
      else $error("frame end did not close the flush phase");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import zst_pkg::*;

   localparam logic                 KIND_PIXEL   = 1'b0;
   localparam logic                 KIND_FLUSH   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int                   IDLE_LIMIT   = 2000;
   localparam int                   HOLD_LEN     = 300;
   localparam int                   RANDOM_ITEMS = 560;

   typedef struct packed {
      logic kind;
      logic pixel;
   } stream_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = 1'b0;
   logic                  req_pixel_in = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_pixel_out;
   logic                  rsp_out_valid;
   logic                  rsp_deleted;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data = '0;

   stream_item_type pending_pixels[$];
   result_type      expected_thinned[$];
   int              failures = 0;
   bit              send_idle_on = 1'b1;
   bit              stall_idle_on = 1'b1;
   int              hold_asks = 0;

   // thinning state mirrored from the block
   bit                 sub_pass_sel;
   int unsigned        width_reg;
   int unsigned        height_reg;
   bit [MAX_WIDTH-1:0] upper_line;
   bit [MAX_WIDTH-1:0] middle_line;
   bit [8:0]           window;
   int unsigned        col_pos;
   int unsigned        row_pos;
   int unsigned        tail_pos;

   zhang_suen_thinning_pass dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic int unsigned clip_size(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // col 0 left, 2 right; row 0 top
   function automatic bit window_bit(int unsigned col, int unsigned row);
      return window[(2 - col) * 3 + row];
   endfunction

   function automatic void rewind_frame();
      col_pos = 0;
      row_pos = 0;
      tail_pos = 0;
   endfunction

   function automatic void reset_thinner();
      sub_pass_sel = 1'b0;
      width_reg = RESET_SIZE;
      height_reg = RESET_SIZE;
      upper_line = '0;
      middle_line = '0;
      window = '0;
      rewind_frame();
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
      case (idx)
         CSR_SUB_PASS: begin
            sub_pass_sel = value[0];
         end
         CSR_IMAGE_WIDTH: begin
            width_reg = 32'(value);
            rewind_frame();
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = 32'(value);
            rewind_frame();
         end
         default: begin
         end
      endcase
   endfunction

   // one stream transaction in, one expected result out
   function automatic void thin_predict(logic kind, logic pix);
      int unsigned w, h, c, q, f, p, prow, pcol, a, b;
      bit          v, tail, ctr, del, m1, m2;
      bit [7:0]    ring;
      result_type  r;
      w = clip_size(width_reg, MAX_WIDTH);
      h = clip_size(height_reg, MAX_HEIGHT);
      v = (kind == KIND_FLUSH) ? 1'b0 : pix;
      tail = tail_pos != 0;
      f = 0;
      if (!tail) begin
         if (col_pos >= w || row_pos >= h) rewind_frame();
         c = col_pos;
         q = row_pos * w + c;
      end else begin
         f = tail_pos - 1;
         if (f > w) f = w;
         c = (f < w) ? f : 0;
         q = w * h + f;
         v = 1'b0;
      end
      if (c >= MAX_WIDTH) c = 0;
      window = {window[5:0], v, middle_line[c], upper_line[c]};
      upper_line[c] = middle_line[c];
      middle_line[c] = v;

      r = '0;
      if (q >= w + 1) begin
         p = q - w - 1;
         prow = p / w;
         pcol = p % w;
         ctr = window_bit(1, 1);
         del = 1'b0;
         // ring[0] is north, going clockwise
         ring = {window_bit(0, 0), window_bit(0, 1), window_bit(0, 2), window_bit(1, 2),
                 window_bit(2, 2), window_bit(2, 1), window_bit(2, 0), window_bit(1, 0)};
         if (ctr && prow >= 1 && prow + 2 <= h && pcol >= 1 && pcol + 2 <= w) begin
            a = 0;
            b = 0;
            for (int i = 0; i < 8; i++) begin
               if (!ring[i] && ring[(i + 1) % 8]) a++;
               b += ring[i];
            end
            if (sub_pass_sel) begin
               m1 = ring[0] & ring[2] & ring[6];
               m2 = ring[0] & ring[4] & ring[6];
            end else begin
               m1 = ring[0] & ring[2] & ring[4];
               m2 = ring[2] & ring[4] & ring[6];
            end
            del = (a == 1) && (b >= NB_MIN) && (b <= NB_MAX) && !m1 && !m2;
         end
         r.pixel_out = ctr & ~del;
         r.out_valid = 1'b1;
         r.deleted   = del;
         r.frame_end = (p == w * h - 1);
      end
      expected_thinned.push_back(r);

      if (!tail) begin
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
               row_pos = 0;
               tail_pos = 1;
            end
         end
      end else if (f >= w) begin
         rewind_frame();
      end else begin
         tail_pos = f + 2;
      end
   endfunction

   function automatic void queue_item(logic kind, logic pix);
      stream_item_type it;
      it.kind = kind;
      it.pixel = pix;
      pending_pixels.push_back(it);
   endfunction

   function automatic void queue_pattern(bit [8:0] rows);
      for (int i = 8; i >= 0; i--) queue_item(KIND_PIXEL, rows[i]);
   endfunction

   // a full frame plus its flush tail; broken frames mix kinds, resize the tail
   function automatic int queue_frame(int unsigned w, int unsigned h, bit allow_noise);
      int unsigned density, flush_len, count;
      bit          broken;
      case ($urandom_range(0, 3))
         0: density = 20;
         1: density = 50;
         2: density = 75;
         default: density = $urandom_range(0, 100);
      endcase
      broken = allow_noise && ($urandom_range(0, 99) < 15);
      count = 0;
      for (int unsigned i = 0; i < w * h; i++) begin
         if (broken && $urandom_range(0, 99) < 5)
            queue_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
         else
            queue_item(KIND_PIXEL, $urandom_range(0, 99) < density);
         count++;
      end
      flush_len = w + 1;
      if (broken && $urandom_range(0, 1)) flush_len = $urandom_range(0, w + 3);
      for (int unsigned i = 0; i < flush_len; i++) begin
         if (broken && $urandom_range(0, 99) < 20)
            queue_item(KIND_PIXEL, 1'($urandom_range(0, 1)));
         else
            queue_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
         count++;
      end
      return count;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CFG_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      apply_reg_write(idx, value[CFG_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // wait until the pipe is empty, then give the block its latency
   task automatic settle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_thinned.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // pixel driver
   int send_gap = 0;
   always @(posedge clock) begin
      stream_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) thin_predict(req_kind, req_pixel_in);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               next_item = pending_pixels.pop_front();
               req_valid    <= 1'b1;
               req_kind     <= next_item.kind;
               req_pixel_in <= next_item.pixel;
               send_gap = (send_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   int stall_left = 0;
   int hold_done = 0;
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_thinned.size() == 0) begin
               $error("result transaction with nothing expected");
               failures++;
            end else begin
               want = expected_thinned.pop_front();
               if (rsp_pixel_out !== want.pixel_out) begin
                  $error("pixel_out: expected %0b, got %0b", want.pixel_out, rsp_pixel_out);
                  failures++;
               end
               if (rsp_out_valid !== want.out_valid) begin
                  $error("out_valid: expected %0b, got %0b", want.out_valid, rsp_out_valid);
                  failures++;
               end
               if (rsp_deleted !== want.deleted) begin
                  $error("deleted: expected %0b, got %0b", want.deleted, rsp_deleted);
                  failures++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_done != hold_asks) begin
            hold_done++;
            stall_left = HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else if (stall_idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      int unsigned w, h, queued;
      reset_thinner();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 3x3 frame: L corner at the center goes on the first rule
      write_reg(CSR_IMAGE_WIDTH, 3);
      write_reg(CSR_IMAGE_HEIGHT, 3);
      write_reg(CSR_SUB_PASS, 0);
      write_reg(CSR_UNUSED, 11'h7FF);
      queue_pattern(9'b110_110_000);
      pending_pixels.pop_back();
      queue_item(KIND_FLUSH, 1'b1);   // flush inside the frame reads as 0
      queue_item(KIND_FLUSH, 1'b1);
      queue_item(KIND_PIXEL, 1'b1);   // pixel in the tail is ignored
      queue_item(KIND_FLUSH, 1'b0);
      queue_item(KIND_FLUSH, 1'b1);
      settle();

      // mirrored corner, deleted on the second rule
      write_reg(CSR_SUB_PASS, 1);
      queue_pattern(9'b000_011_011);
      repeat (4) queue_item(KIND_FLUSH, 1'b0);

      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         settle();
         w = $urandom_range(3, 12);
         h = $urandom_range(3, 10);
         write_reg(CSR_IMAGE_WIDTH, w);
         write_reg(CSR_IMAGE_HEIGHT, h);
         write_reg(CSR_SUB_PASS, $urandom_range(0, 1));
         send_idle_on = $urandom_range(0, 3) != 0;
         stall_idle_on = $urandom_range(0, 3) != 0;
         if (queued == 0) begin
            // long receiver hold while the sender keeps pushing
            send_idle_on = 1'b0;
            hold_asks++;
         end
         repeat ($urandom_range(1, 3)) queued += queue_frame(w, h, 1'b1);
      end

      // sizes below the floor clamp to a 3x3 frame
      settle();
      send_idle_on = 1'b1;
      stall_idle_on = 1'b1;
      write_reg(CSR_IMAGE_WIDTH, 1);
      write_reg(CSR_IMAGE_HEIGHT, 0);
      write_reg(CSR_SUB_PASS, 0);
      void'(queue_frame(MIN_SIZE, MIN_SIZE, 1'b0));

      // sizes above the ceiling: the start of the widest frame
      settle();
      write_reg(CSR_IMAGE_WIDTH, 2047);
      write_reg(CSR_IMAGE_HEIGHT, 2047);
      write_reg(CSR_SUB_PASS, 1);
      repeat (40) queue_item(KIND_PIXEL, 1'($urandom_range(0, 1)));

      // the start of the tallest frame
      settle();
      write_reg(CSR_IMAGE_WIDTH, 2);
      write_reg(CSR_IMAGE_HEIGHT, 1500);
      write_reg(CSR_SUB_PASS, 0);
      repeat (60) queue_item(KIND_PIXEL, 1'($urandom_range(0, 1)));

      settle();
      if (failures == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/zst_pkg.sv
rtl/zst_ram.sv
rtl/zst_decide.sv
rtl/zhang_suen_thinning_pass.sv
verif/testbench.sv
